@@ src/tsd_pkg.sv @@
`timescale 1ns / 1ps

package tsd_pkg;

  localparam int MAX_DELIM_BYTES = 8;
  localparam int BYTE_W          = 8;
  localparam int PATTERN_W       = MAX_DELIM_BYTES * BYTE_W;
  localparam int LEN_W           = 4;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 64;
  localparam int FILL_W          = $clog2(MAX_DELIM_BYTES + 1);
  localparam int IDX_W           = (MAX_DELIM_BYTES > 1) ? $clog2(MAX_DELIM_BYTES) : 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = CFG_IDX_W'(1);

  typedef logic [MAX_DELIM_BYTES-1:0][BYTE_W-1:0] win_t;
  typedef logic [FILL_W-1:0]                      fill_t;

  // What the step logic does with the pending item in a cycle.
  typedef enum logic [2:0] {
    ACT_IDLE,
    ACT_EXCESS,
    ACT_MARK,
    ACT_FLUSH,
    ACT_SEND,
    ACT_KEEP
  } step_act_t;

  // Length register as used: zero counts as one, large values are capped.
  function automatic fill_t eff_len(input logic [LEN_W-1:0] len);
    fill_t res;
    if (len == '0) begin
      res = fill_t'(1);
    end else if (32'(len) > MAX_DELIM_BYTES) begin
      res = fill_t'(MAX_DELIM_BYTES);
    end else begin
      res = fill_t'(len);
    end
    return res;
  endfunction

endpackage

@@ src/tsd_match.sv @@
`timescale 1ns / 1ps

module tsd_match
  import tsd_pkg::*;
(
  input  win_t                  win,
  input  fill_t                 fill,
  input  fill_t                 len,
  input  logic [PATTERN_W-1:0]  pattern,
  output logic                  match
);

  logic [MAX_DELIM_BYTES-1:0] byte_ok;

  // Bytes at or beyond the delimiter length are don't-care.
  always_comb begin
    for (int i = 0; i < MAX_DELIM_BYTES; i++) begin
      byte_ok[i] = (fill_t'(i) >= len) || (win[i] == pattern[i*BYTE_W +: BYTE_W]);
    end
  end

  assign match = (fill == len) && (&byte_ok);

endmodule

@@ src/text_split_on_delimiter_unit.sv @@
`timescale 1ns / 1ps

// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------------
// input    | in_valid / in_ready  | in_text_byte, in_end_of_text
// result   | out_valid / out_ready| out_out_byte, out_byte_valid, out_piece_end,
//          |                      | out_text_end
// config   | cfg_we               | cfg_index, cfg_wdata
//
// One text byte is accepted per cycle unless a result stall, a flush or an
// excess drain holds the input. An accepted byte enters the match window
// at once and is resolved as soon as the result slot allows, giving at most
// one result beat. The final byte flushes each held byte (up to eight), and
// a shortened delimiter drains excess bytes one per cycle while the result
// side takes them. Reset (rst_n low, synchronous) empties the window and the
// result register; window bytes themselves are not reset. A stalled result
// holds its beat while the block keeps taking bytes that need no result.

module text_split_on_delimiter_unit
  import tsd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BYTE_W-1:0]     in_text_byte,
  input  logic                  in_end_of_text,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BYTE_W-1:0]     out_out_byte,
  output logic                  out_byte_valid,
  output logic                  out_piece_end,
  output logic                  out_text_end,

  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers.
  logic [PATTERN_W-1:0] pattern_r;
  logic [LEN_W-1:0]     length_r;

  // Window state: bytes held oldest first, and the count of held bytes.
  win_t  win_r, win_nxt, win_step;
  fill_t fill_r, fill_nxt, fill_step;

  // The byte appended last is still waiting for its resolving step.
  logic pend_r, pend_nxt;
  logic pend_last_r;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_bvalid_r;
  logic              out_pend_r;
  logic              out_tend_r;

  fill_t       len;
  logic        match;
  step_act_t   act;
  logic        emit;
  logic        slot_free;
  logic        step_go;
  logic        finish;
  logic        in_fire;
  logic [BYTE_W-1:0] res_byte;
  logic        res_bvalid;
  logic        res_pend;
  logic        res_tend;

  assign len = eff_len(length_r);

  tsd_match u_match (
    .win     (win_r),
    .fill    (fill_r),
    .len     (len),
    .pattern (pattern_r),
    .match   (match)
  );

  // Pick what the pending byte does this cycle. Excess bytes left by a
  // shortened delimiter go first, then a match, then the end-of-text flush.
  always_comb begin
    act = ACT_IDLE;
    if (pend_r) begin
      if (fill_r > len) begin
        act = ACT_EXCESS;
      end else if (match) begin
        act = ACT_MARK;
      end else if (pend_last_r) begin
        act = ACT_FLUSH;
      end else if (fill_r == len) begin
        act = ACT_SEND;
      end else begin
        act = ACT_KEEP;
      end
    end
  end

  assign emit      = (act == ACT_EXCESS) || (act == ACT_MARK) ||
                     (act == ACT_FLUSH) || (act == ACT_SEND);
  assign slot_free = !out_valid_r || out_ready;
  assign step_go   = pend_r && (!emit || slot_free);

  // Result fields and window update of the chosen step.
  always_comb begin
    res_byte   = win_r[0];
    res_bvalid = 1'b1;
    res_pend   = 1'b0;
    res_tend   = 1'b0;
    finish     = 1'b0;
    win_step   = win_r;
    fill_step  = fill_r;
    for (int i = 0; i < MAX_DELIM_BYTES - 1; i++) begin
      win_step[i] = win_r[i+1];
    end
    case (act)
      ACT_EXCESS: begin
        fill_step = fill_r - fill_t'(1);
      end
      ACT_MARK: begin
        res_byte   = '0;
        res_bvalid = 1'b0;
        res_pend   = 1'b1;
        res_tend   = 1'b1 & pend_last_r;
        fill_step  = '0;
        finish     = 1'b1;
      end
      ACT_FLUSH: begin
        res_pend  = (fill_r == fill_t'(1));
        res_tend  = (fill_r == fill_t'(1));
        fill_step = fill_r - fill_t'(1);
        finish    = (fill_r == fill_t'(1));
      end
      ACT_SEND: begin
        fill_step = fill_r - fill_t'(1);
        finish    = 1'b1;
      end
      ACT_KEEP: begin
        win_step = win_r;
        finish   = 1'b1;
      end
      default: begin
        win_step = win_r;
      end
    endcase
    if (!step_go) begin
      win_step  = win_r;
      fill_step = fill_r;
      finish    = 1'b0;
    end
  end

  // A new byte may enter as soon as the previous one is resolved.
  assign in_ready = !pend_r || finish;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    win_nxt  = win_step;
    fill_nxt = fill_step;
    if (in_fire) begin
      win_nxt[fill_step[IDX_W-1:0]] = in_text_byte;
      fill_nxt = fill_step + fill_t'(1);
    end
  end

  always_comb begin
    pend_nxt = pend_r;
    if (in_fire) begin
      pend_nxt = 1'b1;
    end else if (finish) begin
      pend_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step_go && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r   <= '0;
      length_r    <= LEN_W'(1);
      fill_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == REG_PATTERN)) begin
        pattern_r <= cfg_wdata[PATTERN_W-1:0];
      end
      if (cfg_we && (cfg_index == REG_LENGTH)) begin
        length_r <= cfg_wdata[LEN_W-1:0];
      end
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    if (in_fire) begin
      pend_last_r <= in_end_of_text;
    end
    if (step_go && emit) begin
      out_byte_r   <= res_byte;
      out_bvalid_r <= res_bvalid;
      out_pend_r   <= res_pend;
      out_tend_r   <= res_tend;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_out_byte   = out_byte_r;
  assign out_byte_valid = out_bvalid_r;
  assign out_piece_end  = out_pend_r;
  assign out_text_end   = out_tend_r;

  // The window never holds more than the widest delimiter.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= MAX_DELIM_BYTES)
    else $error("window fill above its capacity");

  // A byte waiting for resolution is always held in the window.
  a_pend_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (fill_r != '0))
    else $error("pending byte with an empty window");

  // Every accepted byte is pending in the next cycle.
  a_accept_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> pend_r)
    else $error("accepted byte not pending");

  // The end of a text always closes a piece.
  a_tend_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tend_r) |-> out_pend_r)
    else $error("text end without piece end");

endmodule

@@ dv/text_split_on_delimiter_unit_tb.sv @@
`timescale 1ns / 1ps

module text_split_on_delimiter_unit_tb;
  import tsd_pkg::*;

  // Register indexes that the block does not implement. A write to them must
  // leave both delimiter registers untouched.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  // A final byte can flush up to eight held bytes, one per ready cycle, so a
  // quiet spell of this many cycles covers any work the block may still have.
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 36;

  // One result beat as the block should present it.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              has_byte;
    logic              ends_piece;
    logic              ends_text;
  } piece_beat_t;

  logic                  clk;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [BYTE_W-1:0]     in_text_byte   = '0;
  logic                  in_end_of_text = 1'b0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [BYTE_W-1:0]     out_out_byte;
  logic                  out_byte_valid;
  logic                  out_piece_end;
  logic                  out_text_end;
  logic                  cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata      = '0;

  // Delimiter settings and match window as the block should hold them.
  logic [PATTERN_W-1:0]  delim_pattern;
  logic [LEN_W-1:0]      delim_len_reg;
  logic [BYTE_W-1:0]     window_bytes [MAX_DELIM_BYTES];
  int                    window_count;

  piece_beat_t           expected_beats [$];
  int                    err_count   = 0;
  int                    cycle_count = 0;
  int                    send_idle_pct  = 0;
  int                    recv_stall_pct = 0;

  text_split_on_delimiter_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_text_byte   (in_text_byte),
    .in_end_of_text (in_end_of_text),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_out_byte   (out_out_byte),
    .out_byte_valid (out_byte_valid),
    .out_piece_end  (out_piece_end),
    .out_text_end   (out_text_end),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Delimiter matching, kept in step with the block. Every task below starts
  // and ends just after a rising edge, and the state here is updated at the
  // edge where a byte or a register write is taken by the block.
  // ---------------------------------------------------------------------------

  // The length register as the matcher uses it: zero acts as one and anything
  // above the window size is capped at the window size.
  function automatic int active_len();
    int len;
    len = int'(delim_len_reg);
    if (len < 1) len = 1;
    if (len > MAX_DELIM_BYTES) len = MAX_DELIM_BYTES;
    return len;
  endfunction

  function automatic logic [BYTE_W-1:0] delim_byte(input int pos);
    return delim_pattern[pos*BYTE_W +: BYTE_W];
  endfunction

  // Removes and returns the oldest byte of the window.
  function automatic logic [BYTE_W-1:0] shift_out_oldest();
    logic [BYTE_W-1:0] oldest;
    oldest = window_bytes[0];
    for (int i = 1; i < window_count; i++) window_bytes[i-1] = window_bytes[i];
    if (window_count > 0) window_count--;
    return oldest;
  endfunction

  function automatic bit window_is_delim(input int len);
    for (int i = 0; i < len; i++) begin
      if (window_bytes[i] != delim_byte(i)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void queue_beat(input logic [BYTE_W-1:0] data, input logic has_byte,
                                     input logic ends_piece, input logic ends_text);
    piece_beat_t beat;
    beat.data       = data;
    beat.has_byte   = has_byte;
    beat.ends_piece = ends_piece;
    beat.ends_text  = ends_text;
    expected_beats = {expected_beats, beat};
  endfunction

  // Works out every result beat that one accepted text byte causes.
  function automatic void split_byte(input logic [BYTE_W-1:0] text_b, input logic is_last);
    int  len;
    bit  tail;
    len = active_len();
    if (window_count >= MAX_DELIM_BYTES) void'(shift_out_oldest());
    window_bytes[window_count] = text_b;
    window_count++;

    // A shortened delimiter leaves surplus bytes that can no longer be part of
    // a match; they go out as ordinary piece bytes.
    while (window_count > len) queue_beat(shift_out_oldest(), 1'b1, 1'b0, 1'b0);

    if (window_count == len && window_is_delim(len)) begin
      // Delimiter found: a byteless marker closes the piece. On the final byte
      // it also closes the text, and no empty trailing piece follows.
      window_count = 0;
      queue_beat('0, 1'b0, 1'b1, is_last);
    end else if (is_last) begin
      while (window_count > 0) begin
        tail = (window_count == 1);
        queue_beat(shift_out_oldest(), 1'b1, tail, tail);
      end
    end else if (window_count == len) begin
      queue_beat(shift_out_oldest(), 1'b1, 1'b0, 1'b0);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random backpressure and the beat-by-beat comparison.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Values read here are the ones present at the edge, since both the block
  // and the drivers above update only through nonblocking assignments.
  always @(posedge clk) begin
    piece_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected result beat: out_byte %0h byte_valid %0b piece_end %0b text_end %0b",
               out_out_byte, out_byte_valid, out_piece_end, out_text_end);
        err_count++;
      end else begin
        want = expected_beats.pop_front();
        if (out_out_byte !== want.data) begin
          $error("out_byte: expected %0h, got %0h", want.data, out_out_byte);
          err_count++;
        end
        if (out_byte_valid !== want.has_byte) begin
          $error("byte_valid: expected %0b, got %0b", want.has_byte, out_byte_valid);
          err_count++;
        end
        if (out_piece_end !== want.ends_piece) begin
          $error("piece_end: expected %0b, got %0b", want.ends_piece, out_piece_end);
          err_count++;
        end
        if (out_text_end !== want.ends_text) begin
          $error("text_end: expected %0b, got %0b", want.ends_text, out_text_end);
          err_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared drivers.
  // ---------------------------------------------------------------------------

  // Offers one text byte, with a random gap before it, and holds it until the
  // block takes it. Valid is left high afterwards so that back-to-back bytes
  // see no bubble; the next call or settle_block decides what follows.
  task automatic send_text_byte(input logic [BYTE_W-1:0] text_b, input logic is_last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_text_byte   <= text_b;
    in_end_of_text <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    split_byte(text_b, is_last);
  endtask

  // Stops the input stream and waits until every expected beat has come out,
  // then a little longer in case the last byte is still being resolved.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The write enable drops for one cycle after each write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx == REG_PATTERN) begin
      delim_pattern = data;
    end else if (idx == REG_LENGTH) begin
      delim_len_reg = data[LEN_W-1:0];
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Sends a text built from whole delimiters, delimiter prefixes and random
  // bytes, so that matches, near misses and empty pieces are all common. If
  // is_done is clear the text is left open and the next one continues it.
  task automatic send_random_text(input bit is_done, output int sent);
    logic [BYTE_W-1:0] text_q [$];
    int                len;
    int                kind;
    int                cut;
    len = active_len();
    repeat ($urandom_range(1, 6)) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        for (int i = 0; i < len; i++) text_q = {text_q, delim_byte(i)};
      end else if (kind < 7) begin
        cut = $urandom_range(1, len);
        for (int i = 0; i < cut; i++) text_q = {text_q, delim_byte(i)};
      end else begin
        repeat ($urandom_range(1, 3)) text_q = {text_q, BYTE_W'($urandom_range(0, 255))};
      end
    end
    foreach (text_q[i]) send_text_byte(text_q[i], is_done && (i == text_q.size() - 1));
    sent = text_q.size();
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset values: a one-byte delimiter of 0x00. Writes to unused indexes must
  // change nothing.
  task automatic test_reset_state();
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, {$urandom, $urandom});
    send_text_byte(8'h00, 1'b0);
    send_text_byte(8'hFF, 1'b0);
    send_text_byte(8'h00, 1'b1);
  endtask

  // Leading, repeated and trailing delimiters: empty pieces appear, but a
  // delimiter on the final byte gives no empty last piece.
  task automatic test_empty_pieces();
    settle_block();
    write_reg(REG_PATTERN, {$urandom, 24'($urandom_range(0, 16777215)), 8'h2C});
    write_reg(REG_LENGTH, CFG_DATA_W'(1));
    send_text_byte(8'h2C, 1'b0);
    send_text_byte(8'h2C, 1'b0);
    send_text_byte(8'h61, 1'b0);
    send_text_byte(8'h2C, 1'b1);
  endtask

  // "aaa" split at "aa": the first match consumes two bytes, so the third one
  // is a piece of its own.
  task automatic test_overlapping_match();
    settle_block();
    write_reg(REG_PATTERN, {48'h0, 16'h6161});
    write_reg(REG_LENGTH, CFG_DATA_W'(2));
    send_text_byte(8'h61, 1'b0);
    send_text_byte(8'h61, 1'b0);
    send_text_byte(8'h61, 1'b1);
  endtask

  // Widest delimiter of all ones, missed on the final byte: the whole window
  // flushes in one go, the largest burst of beats one byte can cause.
  task automatic test_longest_delimiter();
    settle_block();
    write_reg(REG_PATTERN, '1);
    write_reg(REG_LENGTH, CFG_DATA_W'(MAX_DELIM_BYTES));
    repeat (MAX_DELIM_BYTES - 1) send_text_byte(8'hFF, 1'b0);
    send_text_byte(8'h00, 1'b1);
  endtask

  // Length register out of range in both directions, and shortened while a
  // text is open: a length of fifteen acts as eight, then zero acts as one and
  // the surplus held bytes drain ahead of the match marker.
  task automatic test_length_limits();
    settle_block();
    write_reg(REG_LENGTH, CFG_DATA_W'(15));
    write_reg(REG_PATTERN, {$urandom, 24'($urandom_range(0, 16777215)), 8'h41});
    send_text_byte(8'h78, 1'b0);
    send_text_byte(8'h79, 1'b0);
    send_text_byte(8'h7A, 1'b0);
    settle_block();
    write_reg(REG_LENGTH, CFG_DATA_W'(0));
    send_text_byte(8'h41, 1'b1);
  endtask

  // One phase of random texts under a fresh delimiter and a given idling mix.
  // A phase may leave its last text open, so the next delimiter change lands
  // mid-text.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    logic [CFG_DATA_W-1:0] len_word;
    int                    sent;
    int                    total;
    int                    kind;
    settle_block();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;

    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      write_reg(REG_PATTERN, '0);
    end else if (kind == 1) begin
      write_reg(REG_PATTERN, '1);
    end else begin
      write_reg(REG_PATTERN, {$urandom, $urandom});
    end

    // Mostly legal lengths; now and then zero or an oversized value. Upper
    // bits of the write word are random and must be ignored.
    len_word = {$urandom, $urandom};
    if ($urandom_range(0, 6) == 0) begin
      len_word[LEN_W-1:0] = ($urandom_range(0, 1) == 0) ? LEN_W'(0)
                                                         : LEN_W'($urandom_range(9, 15));
    end else begin
      len_word[LEN_W-1:0] = LEN_W'($urandom_range(1, MAX_DELIM_BYTES));
    end
    write_reg(REG_LENGTH, len_word);

    total = 0;
    while (total < PHASE_ITEMS) begin
      send_random_text($urandom_range(0, 9) != 0, sent);
      total += sent;
    end
    if ($urandom_range(0, 1) == 1) send_random_text(1'b0, sent);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence.
  // ---------------------------------------------------------------------------

  initial begin
    delim_pattern = '0;
    delim_len_reg = LEN_W'(1);
    window_count  = 0;
    foreach (window_bytes[i]) window_bytes[i] = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_empty_pieces();
    test_overlapping_match();
    test_longest_delimiter();
    test_length_limits();

    // Idling mixes in turn: none, sender mostly idle, receiver mostly stalled,
    // and light idling on both sides.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin
          test_random_traffic(0, 0);
        end
        1: begin
          test_random_traffic(76, 0);
        end
        2: begin
          test_random_traffic(0, 76);
        end
        default: begin
          test_random_traffic(16, 16);
        end
      endcase
    end

    // Close whatever text is still open so the window ends empty.
    send_text_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
    settle_block();

    if (expected_beats.size() != 0) begin
      $error("%0d expected result beats never arrived", expected_beats.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/tsd_pkg.sv
src/tsd_match.sv
src/text_split_on_delimiter_unit.sv
dv/text_split_on_delimiter_unit_tb.sv
